>>> rtl/core/rls_pkg.sv
`timescale 1ns / 1ps
package rls_pkg;
  localparam int SAMPLE_BITS_DEF = 20;
  localparam int FRAC_BITS_DEF = 12;
  localparam int MIN_START = 100000000;
  localparam int RUN_RESET = 100000;
  localparam int OVERHEAD_RESET = 8;
  localparam int OVH_BITS = 16;
  localparam int RUN_BITS = 20;
  localparam int MIN_BITS = 27;
  localparam int OUT_BITS = 32;
  localparam int ACC_BITS = 64;
  localparam logic CFG_OVERHEAD = 1'b0;
  localparam logic CFG_RUN_LENGTH = 1'b1;
endpackage

>>> rtl/core/rls_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, MSB first.
module rls_divider #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot,
  output logic [DEN_BITS-1:0] rem
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);
  logic [CNT_BITS-1:0] count;
  logic                busy;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   shifted;

  assign shifted = {rem, quot[NUM_BITS-1]};
  assign trial = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CNT_BITS'(NUM_BITS);
      quot <= num;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DEN_BITS]) begin
        rem <= trial[DEN_BITS-1:0];
        quot <= {quot[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted[DEN_BITS-1:0];
        quot <= {quot[NUM_BITS-2:0], 1'b0};
      end
      count <= count - 1'b1;
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

>>> rtl/core/running_latency_statistics.sv
`timescale 1ns / 1ps
// Channel | Dir | Handshake            | Payload
// sample  | in  | sample_valid/stall   | sample_cycles
// stats   | out | stats_valid/stall    | mean_q, stddev_q, min_cycles, max_cycles
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// A sample that closes no run keeps the input stalled through one 64-step pass of the
// shared bit-serial divider with its start and finish, a 32-step shift-add multiply
// and two update states (ACC, CHECK). The last sample of a run goes on with two more
// 64-step divides and a 32-step square root before its result is presented.
// Reset restores registers and clears the run.
// The sample side stalls while an item is in work and while a result waits.
module running_latency_statistics #(
  parameter int SAMPLE_BITS = rls_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS = rls_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [SAMPLE_BITS-1:0]        sample_cycles,
  output logic                          stats_valid,
  input  logic                          stats_stall,
  output logic [rls_pkg::OUT_BITS-1:0]  mean_q,
  output logic [rls_pkg::OUT_BITS-1:0]  stddev_q,
  output logic [rls_pkg::MIN_BITS-1:0]  min_cycles,
  output logic [SAMPLE_BITS-1:0]        max_cycles,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [rls_pkg::RUN_BITS-1:0]  cfg_data
);
  localparam int MB = SAMPLE_BITS + FRAC_BITS;
  localparam int AB = rls_pkg::ACC_BITS;
  localparam int RB = rls_pkg::RUN_BITS;
  localparam int SQ = 2 * FRAC_BITS - 4;
  localparam int PB = 2 * MB;
  localparam int MCNT = $clog2(MB + 1);
  localparam int XB = ((SAMPLE_BITS > rls_pkg::OVH_BITS) ? SAMPLE_BITS
                                                          : rls_pkg::OVH_BITS) + 1;

  typedef enum logic [3:0] {
    IDLE, DIV1, MUL, ACC, CHECK, DIV2, DIV3, SQRT, EMIT
  } state_t;
  state_t state;

  logic [rls_pkg::OVH_BITS-1:0] overhead_cycles;
  logic [RB-1:0] run_length;
  logic [RB-1:0] sample_index;
  logic [MB-1:0] running_mean;
  logic [AB-1:0] deviation_sum;
  logic [rls_pkg::MIN_BITS-1:0] least_seen;
  logic [SAMPLE_BITS-1:0] greatest_seen;

  logic [SAMPLE_BITS-1:0] xs;
  logic [MB-1:0] xq, mag1, mag2;
  logic below;
  logic [RB:0] n_full;
  logic [PB-1:0] prod;
  logic [MB-1:0] mplier;
  logic [MCNT-1:0] mcount;
  logic [AB-1:0] q_hi;
  logic [AB:0] var_v;
  logic var_ovf;
  logic [AB-1:0] sq_v, sq_r, sq_bit;
  logic [5:0] sq_count;

  logic div_start;
  logic div_done;
  logic [AB-1:0] dnum, dquot;
  logic [RB-1:0] dden, drem;

  rls_divider #(.NUM_BITS(AB), .DEN_BITS(RB)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dnum), .den(dden),
    .done(div_done), .quot(dquot), .rem(drem)
  );

  assign cfg_ready = 1'b1;
  assign sample_stall = (state != IDLE);

  logic [XB-1:0] xdiff;
  assign xdiff = XB'(sample_cycles) - XB'(overhead_cycles);
  assign xs = xdiff[XB-1] ? '0 : xdiff[SAMPLE_BITS-1:0];

  logic [RB-1:0] len_eff;
  assign len_eff = (run_length < RB'(2)) ? RB'(2) : run_length;

  logic [MB-1:0] mean_new;
  logic [MB-1:0] q_lo;
  assign q_lo = dquot[MB-1:0];
  assign mean_new = below ? running_mean - q_lo : running_mean + q_lo;

  logic [PB-1:0] shifted_inc;
  logic inc_ovf;
  logic [AB-1:0] inc;
  assign shifted_inc = prod >> SQ;
  assign inc_ovf = (PB - SQ > AB) ? (shifted_inc >> AB) != '0 : 1'b0;
  assign inc = inc_ovf ? '1 : AB'(shifted_inc);
  logic [AB:0] acc_sum;
  assign acc_sum = {1'b0, deviation_sum} + {1'b0, inc};

  logic [AB-1:0] sq_try;
  assign sq_try = sq_r + sq_bit;

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    if (rst) begin
      state <= IDLE;
      overhead_cycles <= rls_pkg::OVH_BITS'(rls_pkg::OVERHEAD_RESET);
      run_length <= RB'(rls_pkg::RUN_RESET);
      sample_index <= '0;
      running_mean <= '0;
      deviation_sum <= '0;
      least_seen <= rls_pkg::MIN_BITS'(rls_pkg::MIN_START);
      greatest_seen <= '0;
      stats_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          rls_pkg::CFG_OVERHEAD: overhead_cycles <= cfg_data[rls_pkg::OVH_BITS-1:0];
          rls_pkg::CFG_RUN_LENGTH: run_length <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        IDLE: begin
          if (sample_valid) begin
            xq <= {xs, {FRAC_BITS{1'b0}}};
            if ({xs, {FRAC_BITS{1'b0}}} >= running_mean) begin
              below <= 1'b0;
              mag1 <= {xs, {FRAC_BITS{1'b0}}} - running_mean;
              dnum <= AB'({xs, {FRAC_BITS{1'b0}}} - running_mean);
            end else begin
              below <= 1'b1;
              mag1 <= running_mean - {xs, {FRAC_BITS{1'b0}}};
              dnum <= AB'(running_mean - {xs, {FRAC_BITS{1'b0}}});
            end
            n_full <= {1'b0, sample_index} + 1'b1;
            dden <= sample_index + 1'b1;
            if (xs > greatest_seen) greatest_seen <= xs;
            if (rls_pkg::MIN_BITS'(xs) < least_seen) least_seen <= rls_pkg::MIN_BITS'(xs);
            div_start <= 1'b1;
            state <= DIV1;
          end
        end
        DIV1: begin
          if (div_done) begin
            running_mean <= mean_new;
            mag2 <= below ? mean_new - xq : xq - mean_new;
            prod <= '0;
            mcount <= MCNT'(MB);
            state <= MUL;
          end
        end
        MUL: begin
          // shift-add, one multiplier bit per cycle
          prod <= (prod << 1) + (mag2[MB-1 - 0] ? PB'(mag1) : '0);
          mag2 <= mag2 << 1;
          mcount <= mcount - 1'b1;
          if (mcount == MCNT'(1)) state <= ACC;
        end
        ACC: begin
          deviation_sum <= acc_sum[AB] ? '1 : acc_sum[AB-1:0];
          sample_index <= n_full[RB-1:0];
          state <= CHECK;
        end
        CHECK: begin
          if (n_full < {1'b0, len_eff}) begin
            state <= IDLE;
          end else begin
            dnum <= deviation_sum;
            dden <= n_full[RB-1:0] - 1'b1;
            div_start <= 1'b1;
            state <= DIV2;
          end
        end
        DIV2: begin
          if (div_done) begin
            q_hi <= dquot;
            dnum <= AB'(drem) << SQ;
            div_start <= 1'b1;
            state <= DIV3;
          end
        end
        DIV3: begin
          if (div_done) begin
            var_ovf <= (q_hi >> (AB - SQ)) != '0;
            var_v <= {1'b0, q_hi << SQ} + {1'b0, dquot};
            sq_v <= (q_hi << SQ) + dquot;
            sq_r <= '0;
            sq_bit <= AB'(1) << (AB - 2);
            sq_count <= 6'd32;
            state <= SQRT;
          end
        end
        SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_count <= sq_count - 1'b1;
          if (sq_count == 6'd1) state <= EMIT;
        end
        EMIT: begin
          if (!stats_valid) begin
            mean_q <= (MB > rls_pkg::OUT_BITS && (running_mean >> rls_pkg::OUT_BITS) != '0)
                      ? '1 : rls_pkg::OUT_BITS'(running_mean);
            stddev_q <= (var_ovf || var_v[AB]) ? '1 : sq_r[rls_pkg::OUT_BITS-1:0];
            min_cycles <= least_seen;
            max_cycles <= greatest_seen;
            stats_valid <= 1'b1;
            sample_index <= '0;
            running_mean <= '0;
            deviation_sum <= '0;
            least_seen <= rls_pkg::MIN_BITS'(rls_pkg::MIN_START);
            greatest_seen <= '0;
          end else if (!stats_stall) begin
            stats_valid <= 1'b0;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/rls_checker.sv
`timescale 1ns / 1ps
module rls_checker #(
  parameter int SAMPLE_BITS = rls_pkg::SAMPLE_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_stall,
  input logic stats_valid,
  input logic stats_stall,
  input logic [rls_pkg::OUT_BITS-1:0] mean_q,
  input logic [rls_pkg::MIN_BITS-1:0] min_cycles,
  input logic [SAMPLE_BITS-1:0] max_cycles
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stats_valid && stats_stall |=> stats_valid && $stable(mean_q))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    stats_valid |-> sample_stall)
    else $error("sample taken while result pending");
  a_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("no work after accept");
  a_minmax: assert property (@(posedge clk) disable iff (rst)
    $rose(stats_valid) |-> (min_cycles == rls_pkg::MIN_BITS'(rls_pkg::MIN_START)) ||
      (min_cycles <= rls_pkg::MIN_BITS'(max_cycles)))
    else $error("min above max");
endmodule

bind running_latency_statistics rls_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (
  .clk(clk), .rst(rst), .sample_valid(sample_valid), .sample_stall(sample_stall),
  .stats_valid(stats_valid), .stats_stall(stats_stall), .mean_q(mean_q),
  .min_cycles(min_cycles), .max_cycles(max_cycles)
);

>>> dv/running_latency_statistics_test.sv
`timescale 1ns / 1ps
module running_latency_statistics_test;
  localparam int SB = rls_pkg::SAMPLE_BITS_DEF;
  localparam int FB = rls_pkg::FRAC_BITS_DEF;
  localparam int OB = rls_pkg::OUT_BITS;
  localparam int NB = rls_pkg::MIN_BITS;
  localparam int RLB = rls_pkg::RUN_BITS;
  localparam int VB = rls_pkg::OVH_BITS;
  localparam int SHR = 2 * FB - 4;
  localparam int MEAN_W = SB + FB;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [OB-1:0] mean;
    logic [OB-1:0] sdev;
    logic [NB-1:0] least;
    logic [SB-1:0] most;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [SB-1:0] sample_cycles = '0;
  logic stats_valid;
  logic stats_stall = 1'b0;
  logic [OB-1:0] mean_q, stddev_q;
  logic [NB-1:0] min_cycles;
  logic [SB-1:0] max_cycles;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = rls_pkg::CFG_OVERHEAD;
  logic [RLB-1:0] cfg_data = '0;

  running_latency_statistics i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_cycles(sample_cycles),
    .stats_valid(stats_valid), .stats_stall(stats_stall),
    .mean_q(mean_q), .stddev_q(stddev_q),
    .min_cycles(min_cycles), .max_cycles(max_cycles),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [VB-1:0] ovh_reg;
  logic [RLB-1:0] len_reg;
  logic [RLB-1:0] n_taken;
  logic [63:0] mean_acc, m2_acc;
  logic [NB-1:0] low_seen;
  logic [SB-1:0] high_seen;

  stats_t pending_stats[$];
  int errors = 0;
  int samples_sent = 0;
  int stats_seen = 0;
  bit hold_rx = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic clear_stats();
    n_taken = '0;
    mean_acc = '0;
    m2_acc = '0;
    low_seen = NB'(rls_pkg::MIN_START);
    high_seen = '0;
  endtask

  task automatic accumulate(input logic [SB-1:0] raw);
    logic [63:0] x, xq, n, d1, d2, inc, q, r, v, add, dv, root;
    logic [127:0] prod;
    logic [63:0] lim;
    stats_t s;
    x = (raw > ovh_reg) ? 64'(raw - ovh_reg) : 64'd0;
    xq = x << FB;
    n = 64'(n_taken) + 64'd1;
    lim = (len_reg < RLB'(2)) ? 64'd2 : 64'(len_reg);
    if (xq >= mean_acc) begin
      d1 = xq - mean_acc;
      mean_acc += d1 / n;
      d2 = xq - mean_acc;
    end else begin
      d1 = mean_acc - xq;
      mean_acc -= d1 / n;
      d2 = mean_acc - xq;
    end
    mean_acc &= (64'd1 << MEAN_W) - 64'd1;
    prod = 128'(d1) * 128'(d2);
    prod = prod >> SHR;
    inc = (prod[127:64] != 0) ? '1 : prod[63:0];
    m2_acc = (m2_acc > ~inc) ? '1 : m2_acc + inc;
    if (x > 64'(high_seen)) high_seen = x[SB-1:0];
    if (x < 64'(low_seen)) low_seen = x[NB-1:0];
    n_taken = n[RLB-1:0];
    if (n >= lim) begin
      dv = n - 64'd1;
      q = m2_acc / dv;
      r = m2_acc % dv;
      s.mean = (mean_acc > 64'hFFFF_FFFF) ? '1 : mean_acc[OB-1:0];
      if (q >= (64'd1 << (64 - SHR))) begin
        s.sdev = '1;
      end else begin
        v = q << SHR;
        add = (r << SHR) / dv;
        if (v > ~add) begin
          s.sdev = '1;
        end else begin
          root = isqrt(v + add);
          s.sdev = root[OB-1:0];
        end
      end
      s.least = low_seen;
      s.most = high_seen;
      pending_stats.push_back(s);
      clear_stats();
    end
  endtask

  // result checker; receiver stall drawn per item
  initial begin
    int gap;
    stats_t want;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap > 0 || hold_rx) begin
        stats_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        while (hold_rx) @(posedge clk);
      end
      stats_stall <= 1'b0;
      @(posedge clk);
      while (!stats_valid) @(posedge clk);
      stats_seen++;
      if (pending_stats.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result at %0t", $realtime);
      end else begin
        want = pending_stats.pop_front();
        if (mean_q !== want.mean) report("mean_q", 64'(mean_q), 64'(want.mean));
        if (stddev_q !== want.sdev) report("stddev_q", 64'(stddev_q), 64'(want.sdev));
        if (min_cycles !== want.least)
          report("min_cycles", 64'(min_cycles), 64'(want.least));
        if (max_cycles !== want.most)
          report("max_cycles", 64'(max_cycles), 64'(want.most));
      end
    end
  end

  // valid stays up after an accept only when the next item follows at once
  task automatic send_sample(input logic [SB-1:0] raw, input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_cycles <= raw;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    accumulate(raw);
    samples_sent++;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    // a sample that finished no run may still be in work
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [RLB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rls_pkg::CFG_OVERHEAD) ovh_reg = val[VB-1:0];
    else len_reg = val;
    @(posedge clk);
  endtask

  task automatic random_sample(output logic [SB-1:0] v);
    case ($urandom_range(0, 5))
      0: v = SB'($urandom_range(0, 40));
      1: v = '1 - SB'($urandom_range(0, 3));
      2: v = SB'($urandom_range(900, 1100));
      default: v = SB'($urandom);
    endcase
  endtask

  task automatic test_extremes();
    logic [SB-1:0] v;
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(2));
    send_sample(SB'(0), 0);
    send_sample('1, 0);
    send_sample('1, 3);
    send_sample('1, 3);
    send_sample(SB'(8), 3);
    send_sample(SB'(9), 3);
    drain();
    write_reg(rls_pkg::CFG_OVERHEAD, RLB'(16'hFFFF));
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(0));
    send_sample(SB'(16'hFFFF), 2);
    send_sample(SB'(20'h10000), 2);
    drain();
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(1));
    send_sample('1, 2);
    send_sample(SB'(0), 2);
    drain();
    write_reg(rls_pkg::CFG_OVERHEAD, RLB'(0));
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(5));
    for (int i = 0; i < 5; i++) begin
      v = (i % 2) ? '1 : '0;
      send_sample(v, 4);
    end
    send_sample(SB'(20'hAAAAA), 4);
    send_sample(SB'(20'h55555), 4);
    drain();
  endtask

  task automatic test_lowered_run_length();
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(10));
    for (int i = 0; i < 6; i++) send_sample(SB'($urandom), 4);
    drain();
    // count already past the new length: next sample closes the run
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(3));
    send_sample(SB'($urandom), 4);
    drain();
  endtask

  task automatic test_random_runs();
    logic [SB-1:0] v;
    int runs_left;
    runs_left = 1500;
    while (runs_left > 0) begin
      write_reg(rls_pkg::CFG_OVERHEAD,
                ($urandom_range(0, 3) == 0) ? RLB'($urandom) : RLB'($urandom_range(0, 64)));
      write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'($urandom_range(2, 40)));
      for (int i = 0; i < 150 && runs_left > 0; i++) begin
        random_sample(v);
        send_sample(v, ($urandom_range(0, 3) == 0) ? 0 : 16);
        runs_left--;
      end
      drain();
    end
  endtask

  task automatic test_back_pressure();
    logic [SB-1:0] v;
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(2));
    hold_rx = 1'b1;
    fork
      begin
        repeat (LONG_HOLD) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 12; i++) begin
        random_sample(v);
        send_sample(v, 0);
      end
    join
    drain();
  endtask

  task automatic test_default_run_length();
    // restore reset value briefly with a long run of 100000 is too slow; use a wide one
    write_reg(rls_pkg::CFG_OVERHEAD, RLB'(8));
    write_reg(rls_pkg::CFG_RUN_LENGTH, RLB'(120));
    for (int i = 0; i < 120; i++) send_sample(SB'($urandom_range(0, 200000)), 1);
    drain();
  endtask

  initial begin
    ovh_reg = VB'(rls_pkg::OVERHEAD_RESET);
    len_reg = RLB'(rls_pkg::RUN_RESET);
    clear_stats();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_lowered_run_length();
    test_back_pressure();
    test_random_runs();
    test_default_run_length();
    $display("Covered %0d samples and %0d statistics results over many run lengths,",
             samples_sent, stats_seen);
    $display("overheads up to full scale, saturation and long output back-pressure.");
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #12ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
